// ===== sv/tsau_pkg.sv =====
// Shared types and codes for the tagged size arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps

package tsau_pkg;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_EQ  = 4'd4;
    localparam logic [3:0] OP_NE  = 4'd5;
    localparam logic [3:0] OP_LT  = 4'd6;
    localparam logic [3:0] OP_GT  = 4'd7;
    localparam logic [3:0] OP_LE  = 4'd8;
    localparam logic [3:0] OP_GE  = 4'd9;

    localparam logic [1:0] TAG_EXACT  = 2'd0;
    localparam logic [1:0] TAG_APPROX = 2'd1;
    localparam logic [1:0] TAG_INF    = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_SUB_INF   = 2'd1;
    localparam logic [1:0] ERR_SUB_UNDER = 2'd2;
    localparam logic [1:0] ERR_DIV       = 2'd3;

    typedef struct packed {
        logic       valid;
        logic [3:0] op;
        logic [1:0] ltag;
        logic [1:0] rtag;
    } ctl_t;

endpackage

// ===== sv/tsau_step.sv =====
// One pipeline step: one shift-add step of the multiplier and one
// restoring step of the divider. Depends on tsau_pkg.
`timescale 1ns / 1ps

module tsau_step
    import tsau_pkg::*;
#(
    parameter int MAG_BITS = 63,
    parameter int STEP     = 0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_t                in_ctl,
    input  logic [MAG_BITS-1:0] in_a,
    input  logic [MAG_BITS-1:0] in_b,
    input  logic [MAG_BITS-1:0] in_sa,
    input  logic                in_aovf,
    input  logic [MAG_BITS-1:0] in_acc,
    input  logic                in_movf,
    input  logic [MAG_BITS-1:0] in_rem,
    input  logic [MAG_BITS-1:0] in_dq,
    output ctl_t                out_ctl,
    output logic [MAG_BITS-1:0] out_a,
    output logic [MAG_BITS-1:0] out_b,
    output logic [MAG_BITS-1:0] out_sa,
    output logic                out_aovf,
    output logic [MAG_BITS-1:0] out_acc,
    output logic                out_movf,
    output logic [MAG_BITS-1:0] out_rem,
    output logic [MAG_BITS-1:0] out_dq
);

    logic [MAG_BITS:0]   sum;
    logic [MAG_BITS:0]   r2;
    logic [MAG_BITS:0]   diff;
    logic                ge;
    logic [MAG_BITS-1:0] acc_next;
    logic                movf_next;
    logic [MAG_BITS-1:0] rem_next;
    logic [MAG_BITS-1:0] dq_next;
    logic                valid_reg;
    logic [3:0]          op_reg;
    logic [1:0]          ltag_reg;
    logic [1:0]          rtag_reg;

    always_comb
    begin
        sum = {1'b0, in_acc} + {1'b0, in_sa};
        if (in_b[STEP])
        begin
            acc_next  = sum[MAG_BITS-1:0];
            movf_next = in_movf | in_aovf | sum[MAG_BITS];
        end
        else
        begin
            acc_next  = in_acc;
            movf_next = in_movf;
        end
        r2       = {in_rem, in_dq[MAG_BITS-1]};
        ge       = r2 >= {1'b0, in_b};
        diff     = r2 - {1'b0, in_b};
        rem_next = ge ? diff[MAG_BITS-1:0] : r2[MAG_BITS-1:0];
        dq_next  = {in_dq[MAG_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= in_ctl.op;
        ltag_reg <= in_ctl.ltag;
        rtag_reg <= in_ctl.rtag;
        out_a    <= in_a;
        out_b    <= in_b;
        out_sa   <= {in_sa[MAG_BITS-2:0], 1'b0};
        out_aovf <= in_aovf | in_sa[MAG_BITS-1];
        out_acc  <= acc_next;
        out_movf <= movf_next;
        out_rem  <= rem_next;
        out_dq   <= dq_next;
    end

    assign out_ctl = '{valid: valid_reg, op: op_reg, ltag: ltag_reg, rtag: rtag_reg};

endmodule

// ===== sv/tagged_size_arithmetic_unit.sv =====
// Top level of the tagged size arithmetic unit: input register, a chain of
// MAG_BITS arithmetic steps and the result stage. Depends on tsau_pkg, tsau_step.
`timescale 1ns / 1ps

// Usage:
// A request is taken at a rising edge where start is high and busy is low.
// busy is always low: the unit is a pipeline that takes one request in every
// cycle, each request carrying an opcode and two tagged operands.
// Every request yields exactly one result, shown on result_kind, result_size,
// truth and error for one cycle while done is high.
// Every opcode passes through the same path: one input register, one
// multiplier/divider step per magnitude bit, and one output register.
// The length of the chain is set by the divider, which resolves one
// quotient bit per step; the multiplier shares the same steps.
// Throughput is one request per cycle.
// Results come out in request order. The receiver cannot stall the unit,
// so it must take each result in the cycle that done is high.
// Reset clears all valid bits at once; no result appears until a request
// has passed through the whole pipeline.
module tagged_size_arithmetic_unit
    import tsau_pkg::*;
#(
    parameter int MAG_BITS = 63
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [3:0]          kind,
    input  logic [1:0]          lhs_kind,
    input  logic [MAG_BITS-1:0] lhs_size,
    input  logic [1:0]          rhs_kind,
    input  logic [MAG_BITS-1:0] rhs_size,
    output logic                done,
    output logic [1:0]          result_kind,
    output logic [MAG_BITS-1:0] result_size,
    output logic                truth,
    output logic [1:0]          error
);

    localparam int LAT = MAG_BITS + 2;

    ctl_t                ctl   [MAG_BITS+1];
    logic [MAG_BITS-1:0] a_s   [MAG_BITS+1];
    logic [MAG_BITS-1:0] b_s   [MAG_BITS+1];
    logic [MAG_BITS-1:0] sa_s  [MAG_BITS+1];
    logic                aovf_s[MAG_BITS+1];
    logic [MAG_BITS-1:0] acc_s [MAG_BITS+1];
    logic                movf_s[MAG_BITS+1];
    logic [MAG_BITS-1:0] rem_s [MAG_BITS+1];
    logic [MAG_BITS-1:0] dq_s  [MAG_BITS+1];

    logic                in_valid_reg;
    logic [3:0]          op_reg;
    logic [1:0]          ltag_reg;
    logic [1:0]          rtag_reg;
    logic [MAG_BITS-1:0] a_reg;
    logic [MAG_BITS-1:0] b_reg;

    logic                done_reg;
    logic [1:0]          kind_reg;
    logic [MAG_BITS-1:0] size_reg;
    logic                truth_reg;
    logic [1:0]          error_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start & ~busy;
            done_reg     <= ctl[MAG_BITS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= kind;
        ltag_reg <= lhs_kind;
        rtag_reg <= rhs_kind;
        a_reg    <= lhs_size;
        b_reg    <= rhs_size;
    end

    always_comb
    begin
        ctl[0].valid = in_valid_reg;
        ctl[0].op    = op_reg;
        ctl[0].ltag  = ltag_reg;
        ctl[0].rtag  = rtag_reg;
        a_s[0]       = a_reg;
        b_s[0]       = b_reg;
        sa_s[0]      = a_reg;
        aovf_s[0]    = 1'b0;
        acc_s[0]     = '0;
        movf_s[0]    = 1'b0;
        rem_s[0]     = '0;
        dq_s[0]      = a_reg;
    end

    for (genvar i = 0; i < MAG_BITS; i++)
    begin : g_step
        tsau_step #(
            .MAG_BITS(MAG_BITS),
            .STEP    (i)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_ctl  (ctl[i]),
            .in_a    (a_s[i]),
            .in_b    (b_s[i]),
            .in_sa   (sa_s[i]),
            .in_aovf (aovf_s[i]),
            .in_acc  (acc_s[i]),
            .in_movf (movf_s[i]),
            .in_rem  (rem_s[i]),
            .in_dq   (dq_s[i]),
            .out_ctl (ctl[i+1]),
            .out_a   (a_s[i+1]),
            .out_b   (b_s[i+1]),
            .out_sa  (sa_s[i+1]),
            .out_aovf(aovf_s[i+1]),
            .out_acc (acc_s[i+1]),
            .out_movf(movf_s[i+1]),
            .out_rem (rem_s[i+1]),
            .out_dq  (dq_s[i+1])
        );
    end

    // Result stage: tags, flags, add, subtract, compares and multiply/divide result selection.
    logic [MAG_BITS-1:0] fa;
    logic [MAG_BITS-1:0] fb;
    logic                linf;
    logic                rinf;
    logic [1:0]          ftag;
    logic [MAG_BITS:0]   add_sum;
    logic                a_lt_b;
    logic                eq;
    logic                lt_ab;
    logic                lt_ba;
    logic [1:0]          kind_next;
    logic [MAG_BITS-1:0] size_next;
    logic                truth_next;
    logic [1:0]          error_next;

    always_comb
    begin
        fa      = a_s[MAG_BITS];
        fb      = b_s[MAG_BITS];
        linf    = ctl[MAG_BITS].ltag[1];
        rinf    = ctl[MAG_BITS].rtag[1];
        ftag    = (ctl[MAG_BITS].ltag == TAG_APPROX || ctl[MAG_BITS].rtag == TAG_APPROX)
                  ? TAG_APPROX : TAG_EXACT;
        add_sum = {1'b0, fa} + {1'b0, fb};
        a_lt_b  = fa < fb;
        if (linf && rinf)
            eq = 1'b1;
        else if (linf || rinf)
            eq = 1'b0;
        else
            eq = (fa == fb);
        lt_ab = !linf && (rinf || a_lt_b);
        lt_ba = !rinf && (linf || (fb < fa));

        kind_next  = TAG_EXACT;
        size_next  = '0;
        truth_next = 1'b0;
        error_next = ERR_NONE;
        unique case (ctl[MAG_BITS].op)
            OP_ADD:
            begin
                if (linf || rinf || add_sum[MAG_BITS])
                    kind_next = TAG_INF;
                else
                begin
                    kind_next = ftag;
                    size_next = add_sum[MAG_BITS-1:0];
                end
            end
            OP_SUB:
            begin
                if (rinf)
                    error_next = ERR_SUB_INF;
                else if (linf)
                    kind_next = TAG_INF;
                else if (a_lt_b)
                    error_next = ERR_SUB_UNDER;
                else
                begin
                    kind_next = ftag;
                    size_next = fa - fb;
                end
            end
            OP_MUL:
            begin
                if (linf || rinf || movf_s[MAG_BITS])
                    kind_next = TAG_INF;
                else
                begin
                    kind_next = ftag;
                    size_next = acc_s[MAG_BITS];
                end
            end
            OP_DIV:
            begin
                if ((!rinf && fb == '0) || (linf && rinf))
                    error_next = ERR_DIV;
                else if (linf)
                    kind_next = TAG_INF;
                else if (rinf)
                    kind_next = TAG_APPROX;
                else
                begin
                    kind_next = ftag;
                    size_next = dq_s[MAG_BITS];
                end
            end
            OP_EQ:   truth_next = eq;
            OP_NE:   truth_next = ~eq;
            OP_LT:   truth_next = lt_ab;
            OP_GT:   truth_next = lt_ba;
            OP_LE:   truth_next = ~lt_ba;
            OP_GE:   truth_next = ~lt_ab;
            default: truth_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        size_reg  <= size_next;
        truth_reg <= truth_next;
        error_reg <= error_next;
    end

    assign done        = done_reg;
    assign result_kind = kind_reg;
    assign result_size = size_reg;
    assign truth       = truth_reg;
    assign error       = error_reg;

`ifndef SYNTHESIS
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching request");
    a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (done && error != ERR_NONE) |-> (result_kind == TAG_EXACT && result_size == '0
            && !truth))
        else $error("error result carries data");
    a_truth_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (done && truth) |-> (result_kind == TAG_EXACT && result_size == '0
            && error == ERR_NONE))
        else $error("comparison result carries data");
    a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_kind == TAG_INF) |-> (result_size == '0))
        else $error("infinite result with nonzero size");
`endif

endmodule
